// ===== hdl/tmrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrt_pkg: shared types and helpers of the texture memory residency tracker
// Field widths, command and status codes, bank size and region overlap logic.
// ----------------------------------------------------------------------------
package tmrt_pkg;

  // fixed field widths
  localparam int BASE_W  = 15;  // bank base in 32-byte units
  localparam int CODE_W  = 3;   // cache width / height code
  localparam int DIM_W   = 11;  // texture width / height
  localparam int PROD_W  = 22;  // width * height
  localparam int NEED_W  = 27;  // width * height * 32
  localparam int RBASE_W = 20;  // region base in bytes
  localparam int BSIZE_W = 24;  // single bank size in bytes
  localparam int RSIZE_W = 25;  // region size after mip doubling
  localparam int RLIM_W  = 26;  // region base + size

  localparam logic [BSIZE_W-1:0] BANK_32K  = BSIZE_W'(32 * 1024);
  localparam logic [BSIZE_W-1:0] BANK_128K = BSIZE_W'(128 * 1024);
  localparam logic [BSIZE_W-1:0] BANK_512K = BSIZE_W'(512 * 1024);
  localparam logic [BSIZE_W-1:0] BANK_UNIT = BSIZE_W'(512);

  localparam logic [CODE_W-1:0] CODE_32K  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_128K = 3'd4;
  localparam logic [CODE_W-1:0] CODE_512K = 3'd5;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_INVAL = 2'd1,
    OP_BIND  = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_VALID   = 2'd1,
    ST_CACHED  = 2'd2
  } status_t;

  // one bank descriptor as written by a config beat
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [CODE_W-1:0] h_code;
    logic [CODE_W-1:0] w_code;
  } bank_code_t;

  // byte region, half-open [base, lim)
  typedef struct packed {
    logic [RBASE_W-1:0] base;
    logic [RLIM_W-1:0]  lim;
  } region_t;

  // regions of one bound unit
  typedef struct packed {
    region_t even;
    region_t odd;
    logic    odd_used;
  } unit_region_t;

  // bank size in bytes from its cache codes
  function automatic logic [BSIZE_W-1:0] bank_bytes(input logic [CODE_W-1:0] w,
                                                    input logic [CODE_W-1:0] h);
    logic [CODE_W:0] sh;
    logic [BSIZE_W-1:0] res;
    sh  = {1'b0, w} + {1'b0, h};
    res = BANK_UNIT << sh;
    if (w == h) begin
      if (w == CODE_32K) res = BANK_32K;
      else if (w == CODE_128K) res = BANK_128K;
      else if (w == CODE_512K) res = BANK_512K;
    end
    return res;
  endfunction

  // both regions are non-empty, so overlap is two compares
  function automatic logic regions_meet(input region_t a, input region_t b);
    return (a.base < b.lim) && (b.base < a.lim);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tmrt_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrt_in_if: command channel of the residency tracker
// Valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface tmrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  unit;
  logic        bank_odd;
  logic [14:0] base_field;
  logic [2:0]  cache_width_code;
  logic [2:0]  cache_height_code;
  logic [10:0] tex_width;
  logic [10:0] tex_height;
  logic        mipmapped;
  logic        wide_texels;

  modport source (
    output valid, opcode, unit, bank_odd, base_field, cache_width_code,
           cache_height_code, tex_width, tex_height, mipmapped, wide_texels,
    input  ready
  );

  modport sink (
    input  valid, opcode, unit, bank_odd, base_field, cache_width_code,
           cache_height_code, tex_width, tex_height, mipmapped, wide_texels,
    output ready
  );
endinterface
`default_nettype wire

// ===== hdl/tmrt_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrt_out_if: status channel of the residency tracker
// Valid/ready handshake carrying one status beat per command.
// ----------------------------------------------------------------------------
interface tmrt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] unit_status;
  logic       is_cached;

  modport source (
    output valid, unit_status, is_cached,
    input  ready
  );

  modport sink (
    input  valid, unit_status, is_cached,
    output ready
  );
endinterface
`default_nettype wire

// ===== hdl/texture_memory_residency_tracker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// texture_memory_residency_tracker_top: residency state of texture units
// Keeps bank descriptors and invalid/valid/cached state per texture unit.
//
// Usage:
//   in_ch takes one command beat (write, invalidate all, bind, query) when
//   valid and ready are high; out_ch returns one status beat per command,
//   the addressed unit's state after the command.
//   Ready is high only while the sequencer is idle; one command at a time.
//   Write, invalidate and query go from accept to the status load; bind
//   passes through two reads of the descriptor memory, two calculation
//   steps, then a scan of the region memory at one stored unit per cycle,
//   a final state update and the status load.
//   The status sits in an output register; if the receiver stalls, the
//   sequencer holds in its last state until the register frees up.
//   Reset (rst_n low, synchronous) marks every unit invalid and every
//   descriptor as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module texture_memory_residency_tracker_top #(
  parameter int NUM_UNITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  tmrt_in_if.sink         in_ch,
  tmrt_out_if.source      out_ch
);

  localparam int IW     = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int UXW    = IW + 3;
  localparam int CDEPTH = 2 ** (IW + 1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_RD_EVEN = 8'b0000_0010,
    S_RD_ODD  = 8'b0000_0100,
    S_CALC    = 8'b0000_1000,
    S_CALC2   = 8'b0001_0000,
    S_SCAN    = 8'b0010_0000,
    S_FIN     = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // unit state as live (valid or cached) and cached bits
  logic [NUM_UNITS-1:0] live_r, live_nxt;
  logic [NUM_UNITS-1:0] cached_r, cached_nxt;

  // latched command
  logic [IW-1:0]             idx_r;
  logic                      ok_r;
  logic                      mip_r, wide_r;
  logic [tmrt_pkg::DIM_W-1:0] tw_r, th_r;

  // bind working registers
  logic [tmrt_pkg::PROD_W-1:0]  prod_r;
  tmrt_pkg::bank_code_t         ev_code_r, od_code_r;
  logic [tmrt_pkg::RBASE_W-1:0] ev_base_r, od_base_r;
  logic [tmrt_pkg::RSIZE_W-1:0] ev_size_r, od_size_r;
  logic                         odd_used_r;
  logic                         fits_r;
  logic                         clash_r;
  tmrt_pkg::unit_region_t       self_reg_r;
  logic [IW-1:0]                scan_idx_r;

  // output register
  logic                  out_vld_r;
  tmrt_pkg::status_t     out_st_r;
  logic                  out_cached_r;

  // input decode
  logic                  in_acc;
  logic [UXW-1:0]        in_unit_x;
  logic [IW-1:0]         in_idx;
  logic                  in_ok;
  logic                  is_write, is_inval, is_bind;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_unit_x   = UXW'(in_ch.unit);
  assign in_idx      = in_unit_x[IW-1:0];
  assign in_ok       = in_unit_x < UXW'(NUM_UNITS);

  always_comb begin
    is_write = 1'b0;
    is_inval = 1'b0;
    is_bind  = 1'b0;
    unique case (in_ch.opcode)
      tmrt_pkg::OP_WRITE: is_write = 1'b1;
      tmrt_pkg::OP_INVAL: is_inval = 1'b1;
      tmrt_pkg::OP_BIND:  is_bind  = 1'b1;
      tmrt_pkg::OP_QUERY: is_write = 1'b0;
      default:            is_write = 1'b0;
    endcase
  end

  // descriptor memory, indexed by {odd bank, unit}
  tmrt_pkg::bank_code_t code_mem [CDEPTH];
  logic [CDEPTH-1:0]    code_vld_r;
  tmrt_pkg::bank_code_t code_rd_r;
  logic                 code_rd_vld_r;
  tmrt_pkg::bank_code_t code_q;
  logic [IW:0]          code_waddr, code_raddr;
  logic                 code_wen, code_ren;

  assign code_wen   = in_acc && is_write && in_ok;
  assign code_waddr = {in_ch.bank_odd, in_idx};
  assign code_ren   = (in_acc && is_bind && in_ok) || (state_r == S_RD_EVEN);
  assign code_raddr = (state_r == S_RD_EVEN) ? {1'b1, idx_r} : {1'b0, in_idx};
  // an entry never written reads as zero
  assign code_q     = code_rd_vld_r ? code_rd_r : '0;

  always_ff @(posedge clk) begin
    if (code_wen) begin
      code_mem[code_waddr] <= '{base:   in_ch.base_field,
                                h_code: in_ch.cache_height_code,
                                w_code: in_ch.cache_width_code};
    end
    if (code_ren) begin
      code_rd_r     <= code_mem[code_raddr];
      code_rd_vld_r <= code_vld_r[code_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_vld_r <= '0;
    end else if (code_wen) begin
      code_vld_r[code_waddr] <= 1'b1;
    end
  end

  // region memory, written at bind, read by the scan
  tmrt_pkg::unit_region_t reg_mem [NUM_UNITS];
  tmrt_pkg::unit_region_t reg_rd_r;
  tmrt_pkg::unit_region_t self_nxt;
  logic                   reg_ren;
  logic [IW-1:0]          reg_raddr;
  logic                   scan_last;

  assign scan_last = (scan_idx_r == IW'(NUM_UNITS - 1));
  assign reg_ren   = (state_r == S_CALC2) || ((state_r == S_SCAN) && !scan_last);
  assign reg_raddr = (state_r == S_CALC2) ? '0 : scan_idx_r + IW'(1);

  // a read of the bound unit's own entry during its write is skipped by the scan
  always_ff @(posedge clk) begin
    if (state_r == S_CALC2) begin
      reg_mem[idx_r] <= self_nxt;
    end
    if (reg_ren) begin
      reg_rd_r <= reg_mem[reg_raddr];
    end
  end

  // bind calculation
  logic [tmrt_pkg::BSIZE_W-1:0] ev_bytes, od_bytes;
  logic [tmrt_pkg::NEED_W-1:0]  need;
  logic                         odd_used;
  logic                         fits;

  always_comb begin
    ev_bytes = tmrt_pkg::bank_bytes(ev_code_r.w_code, ev_code_r.h_code);
    od_bytes = tmrt_pkg::bank_bytes(od_code_r.w_code, od_code_r.h_code);
    need     = {prod_r, 5'b0};
    odd_used = mip_r || wide_r;
    fits     = (need <= tmrt_pkg::NEED_W'(ev_bytes)) &&
               (!odd_used || (need <= tmrt_pkg::NEED_W'(od_bytes)));
  end

  // region limits of the bound unit
  always_comb begin
    self_nxt.even.base = ev_base_r;
    self_nxt.even.lim  = tmrt_pkg::RLIM_W'(ev_base_r) + tmrt_pkg::RLIM_W'(ev_size_r);
    self_nxt.odd.base  = od_base_r;
    self_nxt.odd.lim   = tmrt_pkg::RLIM_W'(od_base_r) + tmrt_pkg::RLIM_W'(od_size_r);
    self_nxt.odd_used  = odd_used_r;
  end

  // scan compare against one stored unit
  logic scan_hit;
  logic demote;

  tmrt_overlap u_overlap (
    .self_reg  (self_reg_r),
    .other_reg (reg_rd_r),
    .hit       (scan_hit)
  );

  assign demote = (state_r == S_SCAN) && scan_hit && live_r[scan_idx_r] &&
                  (scan_idx_r != idx_r);

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r  <= in_idx;
      ok_r   <= in_ok;
      mip_r  <= in_ch.mipmapped;
      wide_r <= in_ch.wide_texels;
      tw_r   <= in_ch.tex_width;
      th_r   <= in_ch.tex_height;
    end
    if (state_r == S_RD_EVEN) begin
      ev_code_r <= code_q;
      prod_r    <= tmrt_pkg::PROD_W'(tw_r) * tmrt_pkg::PROD_W'(th_r);
    end
    if (state_r == S_RD_ODD) begin
      od_code_r <= code_q;
    end
    if (state_r == S_CALC) begin
      ev_base_r  <= {ev_code_r.base, 5'b0};
      od_base_r  <= {od_code_r.base, 5'b0};
      ev_size_r  <= mip_r ? {ev_bytes, 1'b0} : {1'b0, ev_bytes};
      od_size_r  <= (mip_r && wide_r) ? {od_bytes, 1'b0} : {1'b0, od_bytes};
      odd_used_r <= odd_used;
      fits_r     <= fits;
    end
    if (state_r == S_CALC2) begin
      self_reg_r <= self_nxt;
      scan_idx_r <= '0;
      clash_r    <= odd_used_r && tmrt_pkg::regions_meet(self_nxt.even, self_nxt.odd);
    end
    if (state_r == S_SCAN) begin
      scan_idx_r <= scan_idx_r + IW'(1);
      if (demote) clash_r <= 1'b1;
    end
  end

  // unit state updates
  always_comb begin
    live_nxt   = live_r;
    cached_nxt = cached_r;
    if (in_acc && is_inval) begin
      live_nxt   = '0;
      cached_nxt = '0;
    end else if (in_acc && is_write && in_ok) begin
      live_nxt[in_idx]   = 1'b0;
      cached_nxt[in_idx] = 1'b0;
    end
    if (demote) begin
      cached_nxt[scan_idx_r] = 1'b0;
    end
    if (state_r == S_FIN) begin
      live_nxt[idx_r]   = 1'b1;
      cached_nxt[idx_r] = fits_r && !clash_r;
    end
  end

  // sequencer
  logic out_load;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (is_bind && in_ok) ? S_RD_EVEN : S_DONE;
      end
      S_RD_EVEN: state_nxt = S_RD_ODD;
      S_RD_ODD:  state_nxt = S_CALC;
      S_CALC:    state_nxt = S_CALC2;
      S_CALC2:   state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_last) state_nxt = S_FIN;
      end
      S_FIN:     state_nxt = S_DONE;
      S_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      live_r    <= '0;
      cached_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      live_r   <= live_nxt;
      cached_r <= cached_nxt;
      if (out_load) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  // status of the addressed unit
  tmrt_pkg::status_t st_sel;

  always_comb begin
    st_sel = tmrt_pkg::ST_INVALID;
    if (ok_r) begin
      if (cached_r[idx_r]) st_sel = tmrt_pkg::ST_CACHED;
      else if (live_r[idx_r]) st_sel = tmrt_pkg::ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_st_r     <= st_sel;
      out_cached_r <= (st_sel == tmrt_pkg::ST_CACHED);
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.unit_status = out_st_r;
  assign out_ch.is_cached   = out_cached_r;

  // checks
  a_cached_is_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cached_r & ~live_r) == '0)
    else $error("cached unit not live");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("command accepted while busy");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (UXW'(scan_idx_r) < UXW'(NUM_UNITS)))
    else $error("scan index out of range");

  a_status_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_DONE))
    else $error("status beat not loaded from done state");

endmodule
`default_nettype wire

// ===== hdl/tmrt_overlap.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrt_overlap: region overlap test of the bind scan
// Compares the bound unit's regions with one stored unit's regions.
// ----------------------------------------------------------------------------
module tmrt_overlap (
  input  tmrt_pkg::unit_region_t self_reg,
  input  tmrt_pkg::unit_region_t other_reg,
  output logic                   hit
);

  logic ee, eo, oe, oo;

  // all four bank pairings, odd banks only where present
  always_comb begin
    ee  = tmrt_pkg::regions_meet(self_reg.even, other_reg.even);
    eo  = other_reg.odd_used && tmrt_pkg::regions_meet(self_reg.even, other_reg.odd);
    oe  = self_reg.odd_used && tmrt_pkg::regions_meet(self_reg.odd, other_reg.even);
    oo  = self_reg.odd_used && other_reg.odd_used &&
          tmrt_pkg::regions_meet(self_reg.odd, other_reg.odd);
    hit = ee || eo || oe || oo;
  end

endmodule
`default_nettype wire

// ===== dv/texture_memory_residency_tracker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_memory_residency_tracker_top_tb: residency tracker testbench
// Sends write, invalidate, bind and query commands through the command
// channel. A shadow copy of the bank descriptors, bound regions and unit
// states predicts each status beat, which is checked against the status
// channel in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module texture_memory_residency_tracker_top_tb;

  localparam int NUM_UNITS    = 8;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either channel
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_PRINTS   = 40;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STEADY_ITEMS = 150;

  // one command beat
  typedef struct {
    tmrt_pkg::opcode_t op;
    logic [2:0]        unit;
    logic              odd;
    logic [14:0]       base;
    logic [2:0]        wcode;
    logic [2:0]        hcode;
    logic [10:0]       tw;
    logic [10:0]       th;
    logic              mip;
    logic              wide;
  } residency_cmd_t;

  // one status beat
  typedef struct packed {
    tmrt_pkg::status_t st;
    logic              cached;
  } status_beat_t;

  logic clk;
  logic rst_n;
  int   error_count = 0;
  int   idle_pct = 0;
  int   items_sent = 0;

  status_beat_t expected_status_q[$];

  // shadow of the tracker state
  logic [14:0]       sh_even_base  [NUM_UNITS] = '{default: '0};
  logic [5:0]        sh_even_codes [NUM_UNITS] = '{default: '0};
  logic [14:0]       sh_odd_base   [NUM_UNITS] = '{default: '0};
  logic [5:0]        sh_odd_codes  [NUM_UNITS] = '{default: '0};
  tmrt_pkg::status_t sh_state      [NUM_UNITS] = '{default: tmrt_pkg::ST_INVALID};
  logic [19:0]       sh_even_start [NUM_UNITS] = '{default: '0};
  logic [24:0]       sh_even_span  [NUM_UNITS] = '{default: '0};
  logic [19:0]       sh_odd_start  [NUM_UNITS] = '{default: '0};
  logic [24:0]       sh_odd_span   [NUM_UNITS] = '{default: '0};

  tmrt_in_if  in_ch ();
  tmrt_out_if out_ch ();

  texture_memory_residency_tracker_top #(
    .NUM_UNITS(NUM_UNITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // bank size in bytes; width code in bits 2..0, height code in bits 5..3
  function automatic int unsigned bank_span_bytes(logic [5:0] codes);
    int unsigned w;
    int unsigned h;
    int unsigned sz;
    w  = 32'(codes[2:0]);
    h  = 32'(codes[5:3]);
    sz = 32'd512 << (w + h);
    if (w == h && w == 3) sz = 32 * 1024;
    if (w == h && w == 4) sz = 128 * 1024;
    if (w == h && w == 5) sz = 512 * 1024;
    return sz;
  endfunction

  // half-open byte ranges share at least one byte
  function automatic bit spans_overlap(int unsigned a, int unsigned sa,
                                       int unsigned b, int unsigned sb);
    return (a <= b && a + sa > b) || (b <= a && b + sb > a);
  endfunction

  // drop every other live unit touching the range back to valid
  function automatic bit demote_overlapping(int self, int unsigned start,
                                            int unsigned span);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_UNITS; i++) begin
      if (i == self || sh_state[i] == tmrt_pkg::ST_INVALID) continue;
      if (spans_overlap(start, span, 32'(sh_even_start[i]), 32'(sh_even_span[i])) ||
          (sh_odd_span[i] != 0 &&
           spans_overlap(start, span, 32'(sh_odd_start[i]), 32'(sh_odd_span[i])))) begin
        hit = 1'b1;
        sh_state[i] = tmrt_pkg::ST_VALID;
      end
    end
    return hit;
  endfunction

  // regions, fit test and overlap demotion of one bind
  function automatic void bind_texture(int u, logic [10:0] tw, logic [10:0] th,
                                       logic mip, logic wide);
    longint unsigned need;
    bit fits;
    bit clash;
    need = longint'(tw) * longint'(th) * 64'd32;
    sh_even_start[u] = {sh_even_base[u], 5'b0};
    sh_even_span[u]  = 25'(bank_span_bytes(sh_even_codes[u]));
    fits = need <= 64'(sh_even_span[u]);
    if (mip || wide) begin
      sh_odd_start[u] = {sh_odd_base[u], 5'b0};
      sh_odd_span[u]  = 25'(bank_span_bytes(sh_odd_codes[u]));
      fits = fits && need <= 64'(sh_odd_span[u]);
    end else begin
      sh_odd_span[u] = '0;
    end
    // mip chain doubles the footprint, odd bank only for 32-bit texels
    if (mip) begin
      sh_even_span[u] = sh_even_span[u] << 1;
      if (wide) sh_odd_span[u] = sh_odd_span[u] << 1;
    end
    sh_state[u] = fits ? tmrt_pkg::ST_CACHED : tmrt_pkg::ST_VALID;
    clash = sh_odd_span[u] != 0 &&
            spans_overlap(32'(sh_even_start[u]), 32'(sh_even_span[u]),
                          32'(sh_odd_start[u]), 32'(sh_odd_span[u]));
    if (demote_overlapping(u, 32'(sh_even_start[u]), 32'(sh_even_span[u])))
      clash = 1'b1;
    if (sh_odd_span[u] != 0 &&
        demote_overlapping(u, 32'(sh_odd_start[u]), 32'(sh_odd_span[u])))
      clash = 1'b1;
    if (clash) sh_state[u] = tmrt_pkg::ST_VALID;
  endfunction

  // apply one command to the shadow and return the status it should report
  function automatic status_beat_t predict_status(residency_cmd_t c);
    status_beat_t r;
    case (c.op)
      tmrt_pkg::OP_INVAL: begin
        foreach (sh_state[i]) sh_state[i] = tmrt_pkg::ST_INVALID;
      end
      tmrt_pkg::OP_WRITE: begin
        if (c.odd) begin
          sh_odd_base[c.unit]  = c.base;
          sh_odd_codes[c.unit] = {c.hcode, c.wcode};
        end else begin
          sh_even_base[c.unit]  = c.base;
          sh_even_codes[c.unit] = {c.hcode, c.wcode};
        end
        sh_state[c.unit] = tmrt_pkg::ST_INVALID;
      end
      tmrt_pkg::OP_BIND: begin
        bind_texture(int'(c.unit), c.tw, c.th, c.mip, c.wide);
      end
      default: begin
      end
    endcase
    r.st     = sh_state[c.unit];
    r.cached = (r.st == tmrt_pkg::ST_CACHED);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // command with every field random, so ignored fields toggle too
  function automatic residency_cmd_t random_cmd();
    residency_cmd_t c;
    c.op    = tmrt_pkg::opcode_t'(2'($urandom_range(0, 3)));
    c.unit  = 3'($urandom_range(0, 7));
    c.odd   = 1'($urandom_range(0, 1));
    c.base  = 15'($urandom_range(0, 32767));
    c.wcode = 3'($urandom_range(0, 7));
    c.hcode = 3'($urandom_range(0, 7));
    c.tw    = 11'($urandom_range(0, 2047));
    c.th    = 11'($urandom_range(0, 2047));
    c.mip   = 1'($urandom_range(0, 1));
    c.wide  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic residency_cmd_t make_cmd(tmrt_pkg::opcode_t op, int u);
    residency_cmd_t c;
    c      = random_cmd();
    c.op   = op;
    c.unit = 3'(u);
    return c;
  endfunction

  function automatic residency_cmd_t make_write(int u, bit odd, int base,
                                                int wc, int hc);
    residency_cmd_t c;
    c       = make_cmd(tmrt_pkg::OP_WRITE, u);
    c.odd   = odd;
    c.base  = 15'(base);
    c.wcode = 3'(wc);
    c.hcode = 3'(hc);
    return c;
  endfunction

  function automatic residency_cmd_t make_bind(int u, int tw, int th,
                                               bit mip, bit wide);
    residency_cmd_t c;
    c      = make_cmd(tmrt_pkg::OP_BIND, u);
    c.tw   = 11'(tw);
    c.th   = 11'(th);
    c.mip  = mip;
    c.wide = wide;
    return c;
  endfunction

  // drive one command beat and record its expected status once accepted
  task automatic send_cmd(residency_cmd_t c);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.opcode            <= c.op;
    in_ch.unit              <= c.unit;
    in_ch.bank_odd          <= c.odd;
    in_ch.base_field        <= c.base;
    in_ch.cache_width_code  <= c.wcode;
    in_ch.cache_height_code <= c.hcode;
    in_ch.tex_width         <= c.tw;
    in_ch.tex_height        <= c.th;
    in_ch.mipmapped         <= c.mip;
    in_ch.wide_texels       <= c.wide;
    in_ch.valid             <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_status_q.push_back(predict_status(c));
    items_sent++;
  endtask

  // status receiver with random stall bursts
  initial begin : status_sink
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        hold = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each status beat with the oldest prediction
  always @(posedge clk) begin
    status_beat_t exp_beat;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch($sformatf("status beat with none pending: status %0d",
                                  out_ch.unit_status));
      end else begin
        exp_beat = expected_status_q.pop_front();
        if (out_ch.unit_status !== exp_beat.st)
          report_mismatch($sformatf("unit_status got %0d want %0d",
                                    out_ch.unit_status, exp_beat.st));
        if (out_ch.is_cached !== exp_beat.cached)
          report_mismatch($sformatf("is_cached got %0d want %0d",
                                    out_ch.is_cached, exp_beat.cached));
      end
    end
  end

  // stop a hung run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("texture_memory_residency_tracker_top_tb: done, errors");
    $finish;
  end

  // freshly reset units report invalid
  task automatic test_reset_state();
    send_cmd(make_cmd(tmrt_pkg::OP_QUERY, 0));
    send_cmd(make_cmd(tmrt_pkg::OP_QUERY, 7));
  endtask

  // exact fit, a bind 128 bytes over, and demotion of an overlapped neighbor
  task automatic test_fit_and_overlap();
    send_cmd(make_bind(0, 4, 4, 1'b0, 1'b0));
    send_cmd(make_bind(1, 4, 5, 1'b0, 1'b0));
    send_cmd(make_cmd(tmrt_pkg::OP_QUERY, 0));
  endtask

  task automatic test_invalidate_all();
    send_cmd(make_cmd(tmrt_pkg::OP_INVAL, 5));
    send_cmd(make_cmd(tmrt_pkg::OP_QUERY, 1));
  endtask

  // fixed bank sizes, mip doubling, odd bank use, self overlap, oversize texture
  task automatic test_bank_shapes();
    send_cmd(make_write(3, 1'b0, 'h0100, 4, 4));
    send_cmd(make_write(3, 1'b1, 'h4000, 5, 5));
    send_cmd(make_bind(3, 64, 64, 1'b1, 1'b0));
    send_cmd(make_cmd(tmrt_pkg::OP_QUERY, 3));
    send_cmd(make_write(2, 1'b0, 'h7fff, 3, 3));
    send_cmd(make_write(2, 1'b1, 'h4000, 7, 7));
    send_cmd(make_bind(2, 32, 32, 1'b0, 1'b1));
    send_cmd(make_cmd(tmrt_pkg::OP_QUERY, 3));
    send_cmd(make_write(4, 1'b0, 0, 0, 7));
    send_cmd(make_bind(4, 2047, 2047, 1'b1, 1'b1));
  endtask

  // uneven codes, and a descriptor write dropping a live unit to invalid
  task automatic test_write_demotes();
    send_cmd(make_write(5, 1'b0, 'h5555, 6, 1));
    send_cmd(make_write(5, 1'b1, 'h2aaa, 1, 6));
    send_cmd(make_bind(5, 1024, 1, 1'b0, 1'b1));
    send_cmd(make_write(3, 1'b1, 'h1234, 2, 2));
    send_cmd(make_cmd(tmrt_pkg::OP_QUERY, 3));
  endtask

  // write-then-bind sequences with random content, plus some noise
  task automatic run_traffic(int count, bit allow_idle);
    int start;
    int u;
    int mode;
    int wc;
    int hc;
    int tw;
    int th;
    bit mip;
    bit wide;
    bit odd;
    start = items_sent;
    idle_pct = 0;
    while (items_sent - start < count) begin
      if (allow_idle && $urandom_range(0, 24) == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 40;
        endcase
      end
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
        send_cmd(random_cmd());
      end else if (mode < 11) begin
        send_cmd(make_cmd(tmrt_pkg::OP_INVAL, $urandom_range(0, 7)));
      end else begin
        u    = $urandom_range(0, 7);
        mip  = 1'($urandom_range(0, 1));
        wide = 1'($urandom_range(0, 1));
        for (int b = 0; b < 2; b++) begin
          odd = 1'(b);
          if (odd && !(mip || wide)) continue;
          if ($urandom_range(0, 2) == 0) continue;
          // mostly small banks so units can stay cached
          if ($urandom_range(0, 3) != 0) begin
            wc = $urandom_range(0, 3);
            hc = $urandom_range(0, 1) ? wc : $urandom_range(0, 3);
          end else if ($urandom_range(0, 1)) begin
            wc = $urandom_range(3, 5);
            hc = wc;
          end else begin
            wc = $urandom_range(0, 7);
            hc = $urandom_range(0, 7);
          end
          send_cmd(make_write(u, odd, $urandom_range(0, 32767), wc, hc));
        end
        // texture sizes around the bank sizes, sometimes anything
        if ($urandom_range(0, 9) == 0) begin
          tw = $urandom_range(0, 2047);
          th = $urandom_range(0, 2047);
        end else begin
          tw = (1 << $urandom_range(0, 6)) + $urandom_range(0, 1);
          th = (1 << $urandom_range(0, 6)) - $urandom_range(0, 1);
        end
        send_cmd(make_bind(u, tw, th, mip, wide));
        if ($urandom_range(0, 1))
          send_cmd(make_cmd(tmrt_pkg::OP_QUERY, $urandom_range(0, 7)));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(RANDOM_ITEMS, 1'b1);
  endtask

  // back-to-back commands with both sides always ready
  task automatic test_steady_stream();
    run_traffic(STEADY_ITEMS, 1'b0);
  endtask

  // reset, test sequence and end of run
  initial begin
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.opcode            <= tmrt_pkg::OP_QUERY;
    in_ch.unit              <= '0;
    in_ch.bank_odd          <= 1'b0;
    in_ch.base_field        <= '0;
    in_ch.cache_width_code  <= '0;
    in_ch.cache_height_code <= '0;
    in_ch.tex_width         <= '0;
    in_ch.tex_height        <= '0;
    in_ch.mipmapped         <= 1'b0;
    in_ch.wide_texels       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 20;
    test_reset_state();
    test_fit_and_overlap();
    test_invalidate_all();
    test_bank_shapes();
    test_write_demotes();
    test_random_traffic();
    test_steady_stream();

    in_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("texture_memory_residency_tracker_top_tb: done, clean");
    end else begin
      $display("texture_memory_residency_tracker_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tmrt_pkg.sv
hdl/tmrt_in_if.sv
hdl/tmrt_out_if.sv
hdl/tmrt_overlap.sv
hdl/texture_memory_residency_tracker_top.sv
dv/texture_memory_residency_tracker_top_tb.sv
